FILE: design/dda_line_point_generator_assert.svh
// ---------------------------------------------------------------------------
// DDA line point generator assertion macros
// Concurrent checks clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef DDA_LINE_POINT_GENERATOR_ASSERT_SVH
`define DDA_LINE_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define DDA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dda_pkg.sv
// ---------------------------------------------------------------------------
// DDA package
// Shared types and constants of the DDA line point generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dda_pkg;

    localparam int PIX_W      = 14;
    localparam int CENTER_W   = 12;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DASH_MODE = 2'd0,
        CFG_CENTER_X  = 2'd1,
        CFG_CENTER_Y  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIVX = 4'b0010,
        ST_DIVY = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

FILE: design/dda_div.sv
// ---------------------------------------------------------------------------
// DDA serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_div #(
    parameter int ND = 30,
    parameter int DW = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [ND-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [ND-1:0] quotient
);

    localparam int CW = $clog2(ND + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [ND-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[ND-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(ND);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[ND-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[ND-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/dda_pixmap.sv
// ---------------------------------------------------------------------------
// DDA pixel mapper
// Rounds both accumulators half away from zero and maps them to screen space.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_pixmap #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic signed [COORD_BITS+FRAC_BITS+1:0] x_acc,
    input  logic signed [COORD_BITS+FRAC_BITS+1:0] y_acc,
    input  logic [dda_pkg::CENTER_W-1:0]           center_x,
    input  logic [dda_pkg::CENTER_W-1:0]           center_y,
    output logic [dda_pkg::PIX_W-1:0]              pixel_x,
    output logic [dda_pkg::PIX_W-1:0]              pixel_y
);

    localparam int AW = COORD_BITS + FRAC_BITS + 2;
    localparam int EW = (COORD_BITS + 4 > dda_pkg::PIX_W) ? COORD_BITS + 4 : dda_pkg::PIX_W;

    logic [AW-1:0] mag_x, mag_y;
    logic [AW:0]   sum_x, sum_y;
    logic [EW-1:0] rx, ry, sx, sy, cx, cy, px, py;

    always_comb begin
        mag_x = x_acc[AW-1] ? AW'(-x_acc) : AW'(x_acc);
        mag_y = y_acc[AW-1] ? AW'(-y_acc) : AW'(y_acc);
        sum_x = {1'b0, mag_x} + ((AW+1)'(1) << (FRAC_BITS - 1));
        sum_y = {1'b0, mag_y} + ((AW+1)'(1) << (FRAC_BITS - 1));
        rx    = EW'(sum_x[AW:FRAC_BITS]);
        ry    = EW'(sum_y[AW:FRAC_BITS]);
        sx    = x_acc[AW-1] ? -rx : rx;
        sy    = y_acc[AW-1] ? -ry : ry;
        cx    = EW'(center_x);
        cy    = EW'(center_y);
        px    = cx + sx;
        py    = cy - sy;
    end

    assign pixel_x = px[dda_pkg::PIX_W-1:0];
    assign pixel_y = py[dda_pkg::PIX_W-1:0];

endmodule

FILE: design/dda_line_point_generator.sv
// ---------------------------------------------------------------------------
// DDA line point generator
// Walks a line between two endpoints and gives one screen point per step.
//
// Input channel s_*: an item with s_tuser = start carries both endpoints;
// the block forms steps = max(|dx|,|dy|) and, if steps is nonzero, divides
// serially for the x and y increments, then gives the first point. An item
// with s_tuser = advance steps the accumulators by one and gives the next
// point; an advance with no line in progress gives nothing. m_tlast marks
// the final point. A start waits on the single restoring divider, which
// runs once per axis; an advance needs none. Until a point is loaded into
// the output register, s_tready stays low and no further item is taken.
// The output register lets s_tready rise again while a point still waits;
// if the receiver stalls, the next point holds in the block until
// m_tready frees the register, and no input is taken meanwhile.
// cfg_*: register writes, always ready, meant while the block is idle.
// Reset (aresetn low, synchronous) clears the control and settings registers and ends any line.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dda_line_point_generator_assert.svh"

module dda_line_point_generator #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // start_x, start_y, end_x, end_y (COORD_BITS each), zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // cmd
    input  logic                                  s_tuser,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // pixel_x [13:0], pixel_y [27:14], zero pad
    output logic [dda_pkg::OUT_DATA_W-1:0]        m_tdata,
    // plot
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dda_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dda_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DW = C + 1;
    localparam int ND = C + F + 2;
    localparam int IW = F + 2;
    localparam int AW = C + F + 2;
    localparam int PW = dda_pkg::PIX_W;

    dda_pkg::state_t state_reg, state_next;

    logic                          active_reg, active_next;
    logic                          parity_reg, parity_next;
    logic [DW-1:0]                 steps_left_reg, steps_left_next;
    logic signed [AW-1:0]          x_acc_reg, x_acc_next, y_acc_reg, y_acc_next;
    logic signed [IW-1:0]          x_inc_reg, x_inc_next, y_inc_reg, y_inc_next;
    logic [DW-1:0]                 mag_y_reg, mag_y_next;
    logic                          neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic                          plot_reg, plot_next, last_reg, last_next;
    logic                          dash_reg;
    logic [dda_pkg::CENTER_W-1:0]  cx_reg, cy_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [PW-1:0]                 m_px_reg, m_px_next, m_py_reg, m_py_next;
    logic                          m_plot_reg, m_plot_next, m_last_reg, m_last_next;

    logic signed [C-1:0]           sx, sy, ex, ey;
    logic signed [DW-1:0]          dx, dy;
    logic [DW-1:0]                 ax, ay, steps_in;
    logic                          in_acc, out_free;
    logic                          div_start, div_done;
    logic [ND-1:0]                 div_dividend, div_quo;
    logic [DW-1:0]                 div_divisor;
    logic [IW-1:0]                 q_ext;
    logic [PW-1:0]                 map_px, map_py;

    assign sx = s_tdata[0*C +: C];
    assign sy = s_tdata[1*C +: C];
    assign ex = s_tdata[2*C +: C];
    assign ey = s_tdata[3*C +: C];

    assign dx       = {ex[C-1], ex} - {sx[C-1], sx};
    assign dy       = {ey[C-1], ey} - {sy[C-1], sy};
    assign ax       = dx[DW-1] ? -dx : dx;
    assign ay       = dy[DW-1] ? -dy : dy;
    assign steps_in = (ax > ay) ? ax : ay;

    assign s_tready  = (state_reg == dda_pkg::ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign q_ext = {1'b0, div_quo[F:0]};

    always_comb begin
        if (state_reg == dda_pkg::ST_IDLE) begin
            div_dividend = (ND'(ax) << F) + ND'(steps_in >> 1);
            div_divisor  = steps_in;
        end else begin
            div_dividend = (ND'(mag_y_reg) << F) + ND'(steps_left_reg >> 1);
            div_divisor  = steps_left_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        active_next     = active_reg;
        parity_next     = parity_reg;
        steps_left_next = steps_left_reg;
        x_acc_next      = x_acc_reg;
        y_acc_next      = y_acc_reg;
        x_inc_next      = x_inc_reg;
        y_inc_next      = y_inc_reg;
        mag_y_next      = mag_y_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        plot_next       = plot_reg;
        last_next       = last_reg;
        div_start       = 1'b0;
        m_valid_next    = m_valid_reg && !m_tready;
        m_px_next       = m_px_reg;
        m_py_next       = m_py_reg;
        m_plot_next     = m_plot_reg;
        m_last_next     = m_last_reg;

        case (state_reg)
            dda_pkg::ST_IDLE: begin
                if (in_acc && s_tuser == dda_pkg::CMD_START) begin
                    x_acc_next      = {{(AW-C-F){sx[C-1]}}, sx, {F{1'b0}}};
                    y_acc_next      = {{(AW-C-F){sy[C-1]}}, sy, {F{1'b0}}};
                    parity_next     = 1'b0;
                    steps_left_next = steps_in;
                    mag_y_next      = ay;
                    neg_x_next      = dx[DW-1];
                    neg_y_next      = dy[DW-1];
                    plot_next       = 1'b1;
                    active_next     = 1'b0;
                    if (steps_in == '0) begin
                        x_inc_next = '0;
                        y_inc_next = '0;
                        last_next  = 1'b1;
                        state_next = dda_pkg::ST_EMIT;
                    end else begin
                        last_next  = 1'b0;
                        div_start  = 1'b1;
                        state_next = dda_pkg::ST_DIVX;
                    end
                end else if (in_acc && active_reg) begin
                    x_acc_next      = x_acc_reg + {{(AW-IW){x_inc_reg[IW-1]}}, x_inc_reg};
                    y_acc_next      = y_acc_reg + {{(AW-IW){y_inc_reg[IW-1]}}, y_inc_reg};
                    plot_next       = dash_reg ? parity_reg : 1'b1;
                    parity_next     = !parity_reg;
                    steps_left_next = steps_left_reg - DW'(1);
                    last_next       = (steps_left_reg == DW'(1));
                    active_next     = (steps_left_reg != DW'(1));
                    state_next      = dda_pkg::ST_EMIT;
                end
            end
            dda_pkg::ST_DIVX: begin
                if (div_done) begin
                    x_inc_next = neg_x_reg ? -q_ext : q_ext;
                    div_start  = 1'b1;
                    state_next = dda_pkg::ST_DIVY;
                end
            end
            dda_pkg::ST_DIVY: begin
                if (div_done) begin
                    y_inc_next  = neg_y_reg ? -q_ext : q_ext;
                    active_next = 1'b1;
                    state_next  = dda_pkg::ST_EMIT;
                end
            end
            dda_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_px_next    = map_px;
                    m_py_next    = map_py;
                    m_plot_next  = plot_reg;
                    m_last_next  = last_reg;
                    state_next   = dda_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dda_pkg::ST_IDLE;
            active_reg     <= 1'b0;
            parity_reg     <= 1'b0;
            steps_left_reg <= '0;
            m_valid_reg    <= 1'b0;
            dash_reg       <= 1'b0;
            cx_reg         <= '0;
            cy_reg         <= '0;
        end else begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            parity_reg     <= parity_next;
            steps_left_reg <= steps_left_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dda_pkg::CFG_DASH_MODE: dash_reg <= cfg_data[0];
                    dda_pkg::CFG_CENTER_X:  cx_reg   <= cfg_data;
                    dda_pkg::CFG_CENTER_Y:  cy_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_acc_reg  <= x_acc_next;
        y_acc_reg  <= y_acc_next;
        x_inc_reg  <= x_inc_next;
        y_inc_reg  <= y_inc_next;
        mag_y_reg  <= mag_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        plot_reg   <= plot_next;
        last_reg   <= last_next;
        m_px_reg   <= m_px_next;
        m_py_reg   <= m_py_next;
        m_plot_reg <= m_plot_next;
        m_last_reg <= m_last_next;
    end

    dda_div #(
        .ND(ND),
        .DW(DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quo)
    );

    dda_pixmap #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_pixmap (
        .x_acc   (x_acc_reg),
        .y_acc   (y_acc_reg),
        .center_x(cx_reg),
        .center_y(cy_reg),
        .pixel_x (map_px),
        .pixel_y (map_py)
    );

    assign m_tdata  = {(dda_pkg::OUT_DATA_W - 2*PW)'(0), m_py_reg, m_px_reg};
    assign m_tuser  = m_plot_reg;
    assign m_tlast  = m_last_reg;
    assign m_tvalid = m_valid_reg;

    `DDA_ASSERT_IMP(a_done_in_div, div_done,
        (state_reg == dda_pkg::ST_DIVX) || (state_reg == dda_pkg::ST_DIVY),
        "divider finished outside a division state")
    `DDA_ASSERT_IMP(a_active_steps, active_reg && (state_reg == dda_pkg::ST_IDLE),
        steps_left_reg != '0, "active line with no steps left")
    `DDA_ASSERT_NXT(a_final_step,
        in_acc && (s_tuser == dda_pkg::CMD_ADVANCE) && active_reg && (steps_left_reg == DW'(1)),
        !active_reg && last_reg,
        "final step did not end the line")
    `DDA_ASSERT_NXT(a_emit_hold,
        (state_reg == dda_pkg::ST_EMIT) && m_valid_reg && !m_tready,
        state_reg == dda_pkg::ST_EMIT, "point loaded over a stalled output")

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// DDA line point generator testbench
// Drives start and advance items into the line generator and writes the three
// settings registers between phases. An internal fixed-point model predicts
// each screen point, and every point that leaves the block is compared field
// by field against the oldest prediction. A short table of directed items
// comes first. Random lines follow, most of them walked to their end, some
// cut short or overrun, under several settings. Both sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC     = 16;
    localparam int SETTLE   = 80;
    localparam int LIMIT    = 2000;
    localparam int ITEMS    = 1400;
    localparam int PHASES   = 8;
    localparam int IDLE_PCT = 21;

    typedef struct packed {
        logic [13:0] px;
        logic [13:0] py;
        logic        plot;
        logic        last;
    } point_t;

    typedef struct {
        bit          is_cfg;
        logic        dash;
        logic [11:0] cx;
        logic [11:0] cy;
        logic        cmd;
        logic [11:0] sx, sy, ex, ey;
        bit          typed;
        point_t      want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [47:0] s_tdata;   // start_x, start_y, end_x, end_y
    logic        s_tuser;   // cmd
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;   // pixel_x, pixel_y, zero pad
    logic        m_tuser;   // plot
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    dda_line_point_generator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state and settings
    logic               dash_on;
    logic [11:0]        org_x, org_y;
    logic signed [29:0] acc_x, acc_y;
    logic signed [17:0] inc_x, inc_y;
    logic [12:0]        steps_left;
    logic               odd_step;
    logic               drawing;

    point_t    pending_points[$];
    stim_row_t directed_rows[$];

    int  errors;
    int  items_sent;
    int  lines_started;
    int  points_seen;
    int  settings_applied;
    int  quiet;
    bit  steady;

    always #5 aclk = ~aclk;

    function automatic int line_span(logic signed [11:0] sx, logic signed [11:0] sy,
                                     logic signed [11:0] ex, logic signed [11:0] ey);
        int dx;
        int dy;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx > dy) ? dx : dy;
    endfunction

    function automatic logic signed [17:0] dda_increment(longint d, int span);
        longint m;
        longint q;
        m = (d < 0) ? -d : d;
        q = ((m <<< FRAC) + (span >>> 1)) / span;
        return (d < 0) ? 18'(-q) : 18'(q);
    endfunction

    function automatic longint round_acc(logic signed [29:0] a);
        longint m;
        m = (a < 0) ? -longint'(a) : longint'(a);
        m = (m + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        return (a < 0) ? -m : m;
    endfunction

    function automatic point_t screen_point(logic plot, logic last);
        point_t p;
        p.px   = 14'(longint'(org_x) + round_acc(acc_x));
        p.py   = 14'(longint'(org_y) - round_acc(acc_y));
        p.plot = plot;
        p.last = last;
        return p;
    endfunction

    task automatic predict_item(input logic cmd, input logic signed [11:0] sx,
                                input logic signed [11:0] sy, input logic signed [11:0] ex,
                                input logic signed [11:0] ey, output bit got,
                                output point_t pt);
        int   span;
        logic plot_now;
        got = 0;
        pt  = '0;
        if (cmd == dda_pkg::CMD_START) begin
            span     = line_span(sx, sy, ex, ey);
            acc_x    = 30'(longint'(sx) <<< FRAC);
            acc_y    = 30'(longint'(sy) <<< FRAC);
            odd_step = 1'b0;
            got      = 1;
            if (span == 0) begin
                inc_x      = '0;
                inc_y      = '0;
                steps_left = '0;
                drawing    = 1'b0;
                pt         = screen_point(1'b1, 1'b1);
            end else begin
                inc_x      = dda_increment(longint'(ex) - longint'(sx), span);
                inc_y      = dda_increment(longint'(ey) - longint'(sy), span);
                steps_left = 13'(span);
                drawing    = 1'b1;
                pt         = screen_point(1'b1, 1'b0);
            end
        end else if (drawing) begin
            acc_x      = acc_x + inc_x;
            acc_y      = acc_y + inc_y;
            plot_now   = dash_on ? odd_step : 1'b1;
            odd_step   = ~odd_step;
            steps_left = steps_left - 13'd1;
            if (steps_left == 0) drawing = 1'b0;
            pt  = screen_point(plot_now, steps_left == 0);
            got = 1;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_item(input logic cmd, input logic [11:0] sx, input logic [11:0] sy,
                             input logic [11:0] ex, input logic [11:0] ey, input bit typed,
                             input point_t want);
        bit     got;
        point_t pt;
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ey, ex, sy, sx};
        do @(posedge aclk); while (!s_tready);
        predict_item(cmd, sx, sy, ex, ey, got, pt);
        if (got) pending_points = {pending_points, (typed ? want : pt)};
        items_sent++;
        if (cmd == dda_pkg::CMD_START) lines_started++;
    endtask

    task automatic drain_points();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input dda_pkg::cfg_idx_t idx, input logic [11:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dda_pkg::CFG_DASH_MODE: dash_on = val[0];
            dda_pkg::CFG_CENTER_X:  org_x   = val;
            dda_pkg::CFG_CENTER_Y:  org_y   = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic dash, input logic [11:0] cx,
                                  input logic [11:0] cy);
        drain_points();
        write_reg(dda_pkg::CFG_DASH_MODE, {11'd0, dash});
        write_reg(dda_pkg::CFG_CENTER_X, cx);
        write_reg(dda_pkg::CFG_CENTER_Y, cy);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic row_item(input logic cmd, input int sx, input int sy, input int ex,
                            input int ey);
        stim_row_t r;
        r        = '{default: '0};
        r.cmd    = cmd;
        r.sx     = 12'(sx);
        r.sy     = 12'(sy);
        r.ex     = 12'(ex);
        r.ey     = 12'(ey);
        directed_rows = {directed_rows, r};
    endtask

    task automatic row_typed(input int sx, input int sy, input int ex, input int ey,
                             input int px, input int py, input logic plot, input logic last);
        stim_row_t r;
        r        = '{default: '0};
        r.cmd    = dda_pkg::CMD_START;
        r.sx     = 12'(sx);
        r.sy     = 12'(sy);
        r.ex     = 12'(ex);
        r.ey     = 12'(ey);
        r.typed  = 1;
        r.want   = '{px: 14'(px), py: 14'(py), plot: plot, last: last};
        directed_rows = {directed_rows, r};
    endtask

    always @(posedge aclk) begin : point_check
        point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            points_seen++;
            if (pending_points.size() == 0) begin
                report_mismatch("point with none pending", m_tdata, 0);
            end else begin
                want = pending_points.pop_front();
                if (m_tdata[13:0] !== want.px) report_mismatch("pixel_x", m_tdata[13:0], want.px);
                if (m_tdata[27:14] !== want.py)
                    report_mismatch("pixel_y", m_tdata[27:14], want.py);
                if (m_tuser !== want.plot) report_mismatch("plot", m_tuser, want.plot);
                if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= LIMIT) begin
                $display("%0t ns: no item moved for %0d cycles", $time, LIMIT);
                $display("dda_line_point_generator regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        stim_row_t   r;
        int          phase;
        int          phase_end;
        int          roll;
        int          span;
        int          n_adv;
        logic [11:0] sx, sy, ex, ey;

        aresetn    = 1'b0;
        s_tdata    = '0;
        s_tuser    = dda_pkg::CMD_START;
        s_tvalid   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = dda_pkg::CFG_DASH_MODE;
        cfg_data   = '0;
        steady     = 0;
        errors     = 0;
        items_sent = 0;
        quiet      = 0;
        dash_on    = 1'b0;
        org_x      = '0;
        org_y      = '0;
        acc_x      = '0;
        acc_y      = '0;
        inc_x      = '0;
        inc_y      = '0;
        steps_left = '0;
        odd_step   = 1'b0;
        drawing    = 1'b0;

        // solid line, origin at 0,0 (reset settings)
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);                  // advance while idle
        row_typed(0, 0, 0, 0, 0, 0, 1'b1, 1'b1);                     // zero length
        row_typed(-2048, -2048, 2047, 2047, -2048, 2048, 1'b1, 1'b0);
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        row_typed(2047, 2047, 2047, -2048, 2047, -2047, 1'b1, 1'b0); // abandons the old line
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        row_item(dda_pkg::CMD_START, 0, 0, 2, 1);                    // half-step ties
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        row_item(dda_pkg::CMD_START, 0, 0, -2, -1);
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);                  // past the end
        // dashed, origin at the far corner
        r        = '{default: '0};
        r.is_cfg = 1;
        r.dash   = 1'b1;
        r.cx     = 12'd4095;
        r.cy     = 12'd4095;
        directed_rows = {directed_rows, r};
        row_typed(-2048, 2047, -2045, 2047, 2047, 2048, 1'b1, 1'b0);
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);                  // gap step
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);
        row_typed(5, -5, 5, -5, 4100, 4100, 1'b1, 1'b1);
        row_typed(2047, -2048, 0, 0, 6142, 6143, 1'b1, 1'b0);
        row_item(dda_pkg::CMD_ADVANCE, 0, 0, 0, 0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.is_cfg)
                apply_settings(r.dash, r.cx, r.cy);
            else
                send_item(r.cmd, r.sx, r.sy, r.ex, r.ey, r.typed, r.want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_settings(1'b0, 12'd0, 12'd0);
                1: apply_settings(1'b1, 12'd4095, 12'd4095);
                2: apply_settings(1'b0, 12'd4095, 12'd0);
                3: apply_settings(1'b1, 12'd0, 12'd4095);
                default: apply_settings(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                                        12'($urandom_range(0, 4095)));
            endcase
            steady    = (phase == 4);
            phase_end = items_sent + ITEMS / PHASES;
            while (items_sent < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    send_item(dda_pkg::CMD_ADVANCE, 12'($urandom), 12'($urandom),
                              12'($urandom), 12'($urandom), 0, '0);
                sx = 12'($urandom);
                sy = 12'($urandom);
                if (roll < 70) begin
                    ex = 12'(int'(sx) + int'($urandom_range(0, 18)) - 9);
                    ey = 12'(int'(sy) + int'($urandom_range(0, 18)) - 9);
                end else if (roll < 85) begin
                    ex = 12'(int'(sx) + int'($urandom_range(0, 120)) - 60);
                    ey = 12'(int'(sy) + int'($urandom_range(0, 120)) - 60);
                end else begin
                    ex = 12'($urandom);
                    ey = 12'($urandom);
                end
                span = line_span(sx, sy, ex, ey);
                send_item(dda_pkg::CMD_START, sx, sy, ex, ey, 0, '0);
                n_adv = (span <= 64) ? span : $urandom_range(0, 12);
                roll  = $urandom_range(0, 99);
                if (roll < 8)
                    n_adv += $urandom_range(1, 3);
                else if (roll < 16 && n_adv > 0)
                    n_adv = $urandom_range(0, n_adv - 1);
                repeat (n_adv)
                    send_item(dda_pkg::CMD_ADVANCE, 12'($urandom), 12'($urandom),
                              12'($urandom), 12'($urandom), 0, '0);
            end
        end
        steady = 0;

        drain_points();
        $display("covered %0d items over %0d lines and %0d settings; %0d points checked",
                 items_sent, lines_started, settings_applied, points_seen);
        if (errors == 0) begin
            $display("dda_line_point_generator regression: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("dda_line_point_generator regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/dda_pkg.sv
design/dda_div.sv
design/dda_pixmap.sv
design/dda_line_point_generator.sv
test/tb_top.sv
